// ----- rtl/core/rau_pkg.sv -----
`timescale 1ns / 1ps

package rau_pkg;

    localparam int unsigned WORD_BITS = 64;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_RED = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_DIVN_START,
        ST_DIVN_WAIT,
        ST_DIVD_START,
        ST_DIVD_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] dividend;
        logic [WORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [WORD_BITS-1:0] quotient;
        logic [WORD_BITS-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- rtl/core/rational_arithmetic_unit_core.sv -----
`timescale 1ns / 1ps
// channel | handshake        | payload
// in      | in_valid/in_stall   | command, a_num, a_den, b_num, b_den
// out     | out_valid/out_stall | res_num, res_den, status
// One transaction at a time; in_stall stays high from acceptance until the
// result is taken. Sequence: the product states ST_MUL0 to ST_MUL2 (none for
// reduce), then one division per Euclid step on the shared 64-bit radix-2
// divider, a check in ST_GCD_START that sees the zero remainder, then two more
// divisions by the gcd. Errors present their result the cycle after acceptance.
// rst_n clears control state asynchronously.
module rational_arithmetic_unit_core
#(
    parameter int unsigned OPERAND_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [63:0] res_num,
    output logic signed [63:0] res_den,
    output logic        status
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]           cmd_reg;
    logic [WORD_BITS-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [WORD_BITS-1:0] p_reg, num_reg, den_reg;
    logic [WORD_BITS-1:0] x_reg, y_reg, g_reg;
    logic [WORD_BITS-1:0] rn_reg, rd_reg;
    logic                 err_reg;
    logic                 accept;
    logic                 err_in;
    logic [WORD_BITS-1:0] an_s, ad_s, bn_s, bd_s;
    logic [WORD_BITS-1:0] mul_a, mul_b, mul_p;
    logic [WORD_BITS-1:0] mn, md;
    div_req_t             dreq;
    div_rsp_t             drsp;

    function automatic logic [WORD_BITS-1:0] sext(input logic [31:0] v);
        logic [OPERAND_BITS-1:0] t;
        t = v[OPERAND_BITS-1:0];
        return WORD_BITS'($signed(t));
    endfunction

    assign an_s = sext(a_num);
    assign ad_s = sext(a_den);
    assign bn_s = sext(b_num);
    assign bd_s = sext(b_den);

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign err_in = (command > CMD_RED) || (ad_s == '0)
                 || (command != CMD_RED && bd_s == '0)
                 || (command == CMD_DIV && bn_s == '0);

    assign mul_p = $signed(mul_a[31:0]) * $signed(mul_b[31:0]);

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            ST_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
            end
            ST_MUL1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            ST_MUL2:
            begin
                mul_a = ad_reg;
                mul_b = (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign mn = num_reg[WORD_BITS-1] ? ('0 - num_reg) : num_reg;
    assign md = den_reg[WORD_BITS-1] ? ('0 - den_reg) : den_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = err_in ? ST_DONE
                               : ((command == CMD_RED) ? ST_GCD_START : ST_MUL0);
            ST_MUL0:       state_next = ST_MUL1;
            ST_MUL1:       state_next = ST_MUL2;
            ST_MUL2:       state_next = ST_GCD_START;
            ST_GCD_START:
                state_next = (y_reg == '0) ? ST_DIVN_START : ST_GCD_WAIT;
            ST_GCD_WAIT:
                if (drsp.done)
                    state_next = ST_GCD_START;
            ST_DIVN_START: state_next = ST_DIVN_WAIT;
            ST_DIVN_WAIT:
                if (drsp.done)
                    state_next = ST_DIVD_START;
            ST_DIVD_START: state_next = ST_DIVD_WAIT;
            ST_DIVD_WAIT:
                if (drsp.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (!out_stall)
                    state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = x_reg;
        dreq.divisor  = y_reg;
        unique case (state_reg)
            ST_GCD_START:
                dreq.start = (y_reg != '0);
            ST_DIVN_START:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = mn;
                dreq.divisor  = g_reg;
            end
            ST_DIVD_START:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = md;
                dreq.divisor  = g_reg;
            end
            default:
                dreq.start = 1'b0;
        endcase
    end

    rau_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                err_reg <= err_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            an_reg  <= an_s;
            ad_reg  <= ad_s;
            bn_reg  <= bn_s;
            bd_reg  <= bd_s;
            num_reg <= an_s;
            den_reg <= ad_s;
            x_reg   <= an_s[WORD_BITS-1] ? ('0 - an_s) : an_s;
            y_reg   <= ad_s[WORD_BITS-1] ? ('0 - ad_s) : ad_s;
        end
        case (state_reg)
            ST_MUL0:
            begin
                p_reg   <= mul_p;
                num_reg <= mul_p;
            end
            ST_MUL1:
                if (cmd_reg == CMD_ADD)
                    num_reg <= p_reg + mul_p;
                else if (cmd_reg == CMD_SUB)
                    num_reg <= p_reg - mul_p;
            ST_MUL2:
            begin
                den_reg <= mul_p;
                x_reg   <= mn;
                y_reg   <= mul_p[WORD_BITS-1] ? ('0 - mul_p) : mul_p;
            end
            ST_GCD_START:
                if (y_reg == '0)
                    g_reg <= (x_reg == '0) ? WORD_BITS'(1) : x_reg;
            ST_GCD_WAIT:
                if (drsp.done)
                begin
                    x_reg <= y_reg;
                    y_reg <= drsp.remainder;
                end
            ST_DIVN_WAIT:
                if (drsp.done)
                    rn_reg <= num_reg[WORD_BITS-1] ? ('0 - drsp.quotient)
                                                   : drsp.quotient;
            ST_DIVD_WAIT:
                if (drsp.done)
                    rd_reg <= den_reg[WORD_BITS-1] ? ('0 - drsp.quotient)
                                                   : drsp.quotient;
            default:
            begin
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign res_num   = err_reg ? '0 : rn_reg;
    assign res_den   = err_reg ? '0 : rd_reg;
    assign status    = err_reg;

endmodule

// ----- rtl/core/rau_divider.sv -----
`timescale 1ns / 1ps

module rau_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] dvs_reg, dvs_next;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;

    assign trial = {rem_reg, quo_reg[WORD_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(WORD_BITS);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_BITS])
            begin
                rem_next = diff[WORD_BITS-1:0];
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WORD_BITS-1:0];
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
